// ----- rtl/byte_ring_buffer_top_defines.svh -----
// Assertion macros for the byte ring buffer.
// Used by byte_ring_buffer_top; depends on clk and rst_n in the using scope.
`ifndef BYTE_RING_BUFFER_TOP_DEFINES_SVH
`define BYTE_RING_BUFFER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BRB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte ring buffer check failed");
`define BRB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte ring buffer check failed");
`else
`define BRB_ASSERT_IMP(lbl, ante, cons)
`define BRB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/brb_pkg.sv -----
// Shared types and constants for the byte ring buffer.
// No dependencies.
package brb_pkg;

  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 3;
  localparam int CFG_W       = 4;
  localparam int CNT_W       = 7;
  localparam int BLK_BYTES   = 8;
  localparam int BLK_W       = BLK_BYTES * BYTE_W;
  localparam int IDX_W       = 3;
  localparam int SIZE_LG_MIN = 1;
  localparam int SIZE_LG_MAX = 8;
  localparam int SIZE_LG_RST = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE       = 3'd0,
    CMD_READ        = 3'd1,
    CMD_READ_BLOCK  = 3'd2,
    CMD_PEEK        = 3'd3,
    CMD_WRITE_BLOCK = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RREQ,
    ST_RDATA,
    ST_WBLK
  } state_t;

endpackage

// ----- rtl/brb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/byte_ring_buffer_top.sv -----
// Byte ring buffer: store in brb_ram, read/write pointers, one-result output register.
// Write, any failure: loaded in DECODE; read, peek: RAM read in DECODE, loaded from RDATA.
// Write_block: WBLK stores bytes in turn; read_block: request, then data, per RAM read.
// One transaction in flight; the next is accepted while the last result waits at the output.
// Synchronous active-low reset clears pointers, state and output valid; size_log2 resets to 8.
// Depends on brb_pkg, brb_ram and byte_ring_buffer_top_defines.svh.
`include "byte_ring_buffer_top_defines.svh"

module byte_ring_buffer_top #(
  parameter int MAX_DEPTH      = 256,
  parameter int MAX_READ_BLOCK = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [brb_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [brb_pkg::CMD_W-1:0]     in_command,
  input  logic [brb_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic [brb_pkg::BLK_W-1:0]     in_block_bytes,
  input  logic [brb_pkg::CNT_W-1:0]     in_count,
  input  logic [brb_pkg::BYTE_W-1:0]    in_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brb_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_ok,
  output logic                          out_last,
  output logic [brb_pkg::BYTE_W-1:0]    out_fill_level
);

  localparam int LgFloor  = $clog2(MAX_DEPTH + 1) - 1;
  localparam int LgMax    = (LgFloor > brb_pkg::SIZE_LG_MAX) ? brb_pkg::SIZE_LG_MAX : LgFloor;
  localparam int AW       = LgMax;
  localparam int MemDepth = 1 << AW;

  brb_pkg::state_t state_r, state_nxt;

  logic [brb_pkg::CFG_W-1:0]  size_log2_r;
  logic [AW-1:0]              rp_r, rp_nxt;
  logic [AW-1:0]              wp_r, wp_nxt;
  logic [brb_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [brb_pkg::IDX_W-1:0]  idx_r, idx_nxt;

  logic [brb_pkg::CMD_W-1:0]  cmd_r;
  logic [brb_pkg::BYTE_W-1:0] data_r;
  logic [brb_pkg::BLK_W-1:0]  block_r;
  logic [brb_pkg::CNT_W-1:0]  cnt_r;
  logic [brb_pkg::BYTE_W-1:0] off_r;

  logic                       out_valid_r;
  logic [brb_pkg::BYTE_W-1:0] ob_r, ob_nxt;
  logic                       ok_r, ok_nxt;
  logic                       last_r, last_nxt;
  logic [brb_pkg::BYTE_W-1:0] fill_r, fill_nxt;
  logic                       out_load;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [brb_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

  logic [brb_pkg::CFG_W-1:0]  lg_clamp, eff_lg;
  logic [AW-1:0]              mask, len, room, peek_addr;
  logic                       out_free, wr_full, rd_empty, rb_bad, pk_ok, wb_bad, wb_last;
  logic                       in_accept;

  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (MemDepth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign lg_clamp = (size_log2_r < brb_pkg::CFG_W'(brb_pkg::SIZE_LG_MIN)) ?
                    brb_pkg::CFG_W'(brb_pkg::SIZE_LG_MIN) :
                    (size_log2_r > brb_pkg::CFG_W'(brb_pkg::SIZE_LG_MAX)) ?
                    brb_pkg::CFG_W'(brb_pkg::SIZE_LG_MAX) : size_log2_r;
  assign eff_lg   = (lg_clamp > brb_pkg::CFG_W'(LgMax)) ? brb_pkg::CFG_W'(LgMax) : lg_clamp;

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      mask[i] = (brb_pkg::CFG_W'(i) < eff_lg);
    end
  end

  assign len       = (wp_r - rp_r) & mask;
  assign room      = mask - len;
  assign peek_addr = (rp_r + off_r[AW-1:0]) & mask;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != brb_pkg::ST_IDLE);

  assign wr_full  = (len == mask);
  assign rd_empty = (len == '0);
  assign rb_bad   = (cnt_r == '0) || (cnt_r > brb_pkg::CNT_W'(MAX_READ_BLOCK)) ||
                    (9'(cnt_r) > 9'(len));
  assign pk_ok    = (9'(off_r) < 9'(len));
  assign wb_bad   = (cnt_r > brb_pkg::CNT_W'(brb_pkg::BLK_BYTES)) || (9'(cnt_r) > 9'(room));
  assign wb_last  = (brb_pkg::CNT_W'(idx_r) + brb_pkg::CNT_W'(1) == cnt_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brb_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = brb_pkg::ST_DECODE;
        end
      end
      brb_pkg::ST_DECODE: begin
        if (out_free) begin
          state_nxt = brb_pkg::ST_IDLE;
          case (cmd_r)
            brb_pkg::CMD_READ: begin
              if (!rd_empty) state_nxt = brb_pkg::ST_RDATA;
            end
            brb_pkg::CMD_READ_BLOCK: begin
              if (!rb_bad) state_nxt = brb_pkg::ST_RDATA;
            end
            brb_pkg::CMD_PEEK: begin
              if (pk_ok) state_nxt = brb_pkg::ST_RDATA;
            end
            brb_pkg::CMD_WRITE_BLOCK: begin
              if (!wb_bad && cnt_r != '0) state_nxt = brb_pkg::ST_WBLK;
            end
            default: state_nxt = brb_pkg::ST_IDLE;
          endcase
        end
      end
      brb_pkg::ST_RREQ: begin
        state_nxt = brb_pkg::ST_RDATA;
      end
      brb_pkg::ST_RDATA: begin
        if (out_free) begin
          state_nxt = (rem_r != '0) ? brb_pkg::ST_RREQ : brb_pkg::ST_IDLE;
        end
      end
      brb_pkg::ST_WBLK: begin
        if (wb_last && out_free) begin
          state_nxt = brb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = brb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    ram_we    = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = data_r;
    ram_re    = 1'b0;
    ram_raddr = rp_r;
    out_load  = 1'b0;
    ob_nxt    = '0;
    ok_nxt    = 1'b0;
    last_nxt  = 1'b1;
    case (state_r)
      brb_pkg::ST_DECODE: begin
        idx_nxt = '0;
        if (out_free) begin
          case (cmd_r)
            brb_pkg::CMD_WRITE: begin
              out_load = 1'b1;
              if (!wr_full) begin
                ram_we = 1'b1;
                wp_nxt = (wp_r + AW'(1)) & mask;
                ok_nxt = 1'b1;
              end
            end
            brb_pkg::CMD_READ: begin
              if (rd_empty) begin
                out_load = 1'b1;
              end else begin
                ram_re  = 1'b1;
                rp_nxt  = (rp_r + AW'(1)) & mask;
                rem_nxt = '0;
              end
            end
            brb_pkg::CMD_READ_BLOCK: begin
              if (rb_bad) begin
                out_load = 1'b1;
              end else begin
                ram_re  = 1'b1;
                rp_nxt  = (rp_r + AW'(1)) & mask;
                rem_nxt = cnt_r - brb_pkg::CNT_W'(1);
              end
            end
            brb_pkg::CMD_PEEK: begin
              if (pk_ok) begin
                ram_re    = 1'b1;
                ram_raddr = peek_addr;
                rem_nxt   = '0;
              end else begin
                out_load = 1'b1;
              end
            end
            brb_pkg::CMD_WRITE_BLOCK: begin
              if (wb_bad) begin
                out_load = 1'b1;
              end else if (cnt_r == '0) begin
                out_load = 1'b1;
                ok_nxt   = 1'b1;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      brb_pkg::ST_RREQ: begin
        ram_re  = 1'b1;
        rp_nxt  = (rp_r + AW'(1)) & mask;
        rem_nxt = rem_r - brb_pkg::CNT_W'(1);
      end
      brb_pkg::ST_RDATA: begin
        if (out_free) begin
          out_load = 1'b1;
          ob_nxt   = ram_rdata;
          ok_nxt   = 1'b1;
          last_nxt = (rem_r == '0);
        end
      end
      brb_pkg::ST_WBLK: begin
        if (!wb_last || out_free) begin
          ram_we    = 1'b1;
          ram_wdata = block_r[{idx_r, 3'b000} +: brb_pkg::BYTE_W];
          wp_nxt    = (wp_r + AW'(1)) & mask;
          idx_nxt   = idx_r + brb_pkg::IDX_W'(1);
          if (wb_last) begin
            out_load = 1'b1;
            ok_nxt   = 1'b1;
          end
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  assign fill_nxt = brb_pkg::BYTE_W'((wp_nxt - rp_nxt) & mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brb_pkg::ST_IDLE;
      size_log2_r <= brb_pkg::CFG_W'(brb_pkg::SIZE_LG_RST);
      rp_r        <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        size_log2_r <= cfg_wr_data;
        rp_r        <= '0;
        wp_r        <= '0;
      end else begin
        rp_r <= rp_nxt;
        wp_r <= wp_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
    if (in_accept) begin
      cmd_r   <= in_command;
      data_r  <= in_data_byte;
      block_r <= in_block_bytes;
      cnt_r   <= in_count;
      off_r   <= in_offset;
    end
    if (out_load) begin
      ob_r   <= ob_nxt;
      ok_r   <= ok_nxt;
      last_r <= last_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = ob_r;
  assign out_ok         = ok_r;
  assign out_last       = last_r;
  assign out_fill_level = fill_r;

  `BRB_ASSERT_IMP(a_load_free, out_load, (!out_valid_r || !out_stall))
  `BRB_ASSERT_NXT(a_wp_hold,
                  (state_r != brb_pkg::ST_DECODE && state_r != brb_pkg::ST_WBLK && !cfg_wr_en),
                  $stable(wp_r))
  `BRB_ASSERT_NXT(a_rp_hold,
                  (state_r != brb_pkg::ST_DECODE && state_r != brb_pkg::ST_RREQ && !cfg_wr_en),
                  $stable(rp_r))
  `BRB_ASSERT_IMP(a_rdata_src, (state_r == brb_pkg::ST_RDATA),
                  ($past(state_r) == brb_pkg::ST_DECODE || $past(state_r) == brb_pkg::ST_RREQ ||
                   $past(state_r) == brb_pkg::ST_RDATA))

endmodule
